// File: hdl/temp_sample_qualify_moving_average_core_macros.svh
// Assertion macros for the temperature sample qualifier core.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef TEMP_SAMPLE_QUALIFY_MOVING_AVERAGE_CORE_MACROS_SVH
`define TEMP_SAMPLE_QUALIFY_MOVING_AVERAGE_CORE_MACROS_SVH

`ifndef SYNTH

// Property checked at every clock edge outside reset.
`define TSQMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: antecedent on one edge, consequent on the next.
`define TSQMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TSQMA_ASSERT(lbl, prop, msg)
`define TSQMA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/tsqma_pkg.sv
// Shared types and constants for the temperature sample qualifier core.
// No dependencies.
package tsqma_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int CODE_W   = 3;
  localparam int TEMP_W   = 18;

  // Filter window; must be a power of two so the mean is a shift
  localparam int WINDOW_LEN = 8;
  localparam int SLOT_W     = $clog2(WINDOW_LEN);
  localparam int SUM_W      = SAMPLE_W + SLOT_W;

  // Mean in hundredths: sum * 100 / (16 * WINDOW_LEN)
  localparam int SCALE     = 100;
  localparam int SCALE_W   = 8;
  localparam int PROD_W    = SUM_W + SCALE_W;
  localparam int DIV_SHIFT = 4 + SLOT_W;
  localparam int DIV_MASK  = (1 << DIV_SHIFT) - 1;

  typedef logic [CODE_W-1:0] err_code_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Error codes
  localparam err_code_t ERR_OK        = 3'd0;
  localparam err_code_t ERR_OPEN_WIRE = 3'd1;
  localparam err_code_t ERR_CRC       = 3'd2;
  localparam err_code_t ERR_RANGE     = 3'd3;
  localparam err_code_t ERR_NO_SENSOR = 3'd4;

  // Configuration register indexes
  localparam logic CFG_LOW_LIMIT  = 1'b0;
  localparam logic CFG_HIGH_LIMIT = 1'b1;

  // Sentinels (-127 and -80 degrees) and reset values
  localparam sample_t SENT_DISCONNECTED = -12'sd2032;
  localparam sample_t SENT_CRC          = -12'sd1280;
  localparam sample_t RESET_SAMPLE      = 12'sd400;
  localparam sample_t RESET_LOW_LIMIT   = -12'sd880;
  localparam sample_t RESET_HIGH_LIMIT  = 12'sd2000;
  localparam logic signed [SUM_W-1:0] RESET_SUM = SUM_W'(400 * WINDOW_LEN);
  localparam logic signed [TEMP_W-1:0] ERROR_VALUE = -18'sd99900;

endpackage

// File: hdl/tsqma_in_if.sv
// Input channel: one raw temperature sample item with valid/ready.
// Depends on tsqma_pkg.
interface tsqma_in_if import tsqma_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_sixteenths;
  logic    sensor_missing;

  modport source (output valid, output sample_sixteenths, output sensor_missing, input ready);
  modport sink   (input valid, input sample_sixteenths, input sensor_missing, output ready);
endinterface

// File: hdl/tsqma_out_if.sv
// Result channel: error code and filtered temperature item with valid/ready.
// Depends on tsqma_pkg.
interface tsqma_out_if import tsqma_pkg::*; ();
  logic                     valid;
  logic                     ready;
  err_code_t                error_code;
  logic signed [TEMP_W-1:0] temp_hundredths;

  modport source (output valid, output error_code, output temp_hundredths, input ready);
  modport sink   (input valid, input error_code, input temp_hundredths, output ready);
endinterface

// File: hdl/temp_sample_qualify_moving_average_core.sv
// Temperature sample qualifier with an 8-entry moving-average filter. One item is
// accepted every clock cycle when the result side keeps up; an accepted item is held
// in the stage 1 register and then in the result register, which drives the result
// handshake. The first stage classifies the sample and updates the running sum of
// the ring in the same cycle, the second stage scales the sum to hundredths of a
// degree through one small constant multiply and a shift. Invalid samples give their
// error code and -99900 and leave the filter alone. After reset every ring entry is
// 25 degrees and the limits are -55 and 125 degrees; the user must write limits over
// the cfg port only while the block is idle, which the block itself does not enforce.
// Depends on tsqma_pkg, tsqma_in_if, tsqma_out_if and the macros header.
`include "temp_sample_qualify_moving_average_core_macros.svh"

module temp_sample_qualify_moving_average_core
  import tsqma_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  tsqma_in_if.sink            in_chan,
  tsqma_out_if.source         out_chan,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_wdata
);

  // Configuration registers
  sample_t low_limit_r, high_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= RESET_LOW_LIMIT;
      high_limit_r <= RESET_HIGH_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOW_LIMIT:  low_limit_r  <= $signed(cfg_wdata);
        CFG_HIGH_LIMIT: high_limit_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Handshake between the stages
  logic in_ready, s2_ready, take, upd;
  logic s1_valid_r, out_valid_r;

  assign s2_ready      = !out_valid_r || out_chan.ready;
  assign in_ready      = !s1_valid_r || s2_ready;
  assign in_chan.ready = in_ready;
  assign take          = in_chan.valid && in_ready;

  // Classification, sentinels first
  sample_t   smp;
  err_code_t code_c;

  assign smp = in_chan.sample_sixteenths;

  always_comb begin
    if (smp == SENT_DISCONNECTED) begin
      code_c = ERR_OPEN_WIRE;
    end else if (smp == SENT_CRC) begin
      code_c = ERR_CRC;
    end else if (smp < low_limit_r || smp > high_limit_r) begin
      code_c = ERR_RANGE;
    end else if (in_chan.sensor_missing) begin
      code_c = ERR_NO_SENSOR;
    end else begin
      code_c = ERR_OK;
    end
  end

  assign upd = take && (code_c == ERR_OK);

  // Ring and running sum
  sample_t                  ring_r [WINDOW_LEN];
  logic [SLOT_W-1:0]        write_slot_r, write_slot_nxt;
  logic signed [SUM_W-1:0]  ring_sum_r, ring_sum_nxt;
  sample_t                  old_smp;

  assign old_smp        = ring_r[write_slot_r];
  assign ring_sum_nxt   = ring_sum_r - SUM_W'(old_smp) + SUM_W'(smp);
  assign write_slot_nxt = (write_slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0
                                                                  : write_slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_r[i] <= RESET_SAMPLE;
      end
      write_slot_r <= '0;
      ring_sum_r   <= RESET_SUM;
    end else if (upd) begin
      ring_r[write_slot_r] <= smp;
      write_slot_r         <= write_slot_nxt;
      ring_sum_r           <= ring_sum_nxt;
    end
  end

  // Stage 1 register: code and updated sum
  err_code_t               s1_code_r;
  logic signed [SUM_W-1:0] s1_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_code_r <= code_c;
      s1_sum_r  <= ring_sum_nxt;
    end
  end

  // Stage 2: sum * 100 / (16 * WINDOW_LEN), truncated toward zero
  logic signed [PROD_W-1:0] prod_c, bias_c, quot_c;
  logic signed [TEMP_W-1:0] value_c;

  assign prod_c  = PROD_W'(s1_sum_r) * PROD_W'(SCALE);
  assign bias_c  = prod_c[PROD_W-1] ? PROD_W'(DIV_MASK) : '0;
  assign quot_c  = (prod_c + bias_c) >>> DIV_SHIFT;
  assign value_c = (s1_code_r == ERR_OK) ? quot_c[TEMP_W-1:0] : ERROR_VALUE;

  // Output register
  err_code_t                out_code_r;
  logic signed [TEMP_W-1:0] out_temp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_code_r <= s1_code_r;
      out_temp_r <= value_c;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.error_code      = out_code_r;
  assign out_chan.temp_hundredths = out_temp_r;

  // Checks
  `TSQMA_ASSERT_NEXT(a_err_keeps_filter, take && (code_c != ERR_OK), $stable(ring_sum_r) && $stable(write_slot_r), "filter changed on an invalid sample")
  `TSQMA_ASSERT(a_err_value, !out_valid_r || (out_code_r == ERR_OK) || (out_temp_r == ERROR_VALUE), "error item without error value")
  `TSQMA_ASSERT(a_ok_range, !out_valid_r || (out_code_r != ERR_OK) || ((out_temp_r >= -18'sd12800) && (out_temp_r <= 18'sd12799)), "filtered value out of range")
  `TSQMA_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s2_ready, s1_valid_r && $stable(s1_sum_r) && $stable(s1_code_r), "stage 1 item lost under stall")

endmodule

// File: dv/temp_sample_qualify_moving_average_core_tb.sv
// Self-checking bench for the temperature sample qualifier and moving-average core.
// Predicts each reading from its own copy of the filter ring and limits, then compares.
// Depends on tsqma_pkg, tsqma_in_if, tsqma_out_if and the core.
module temp_sample_qualify_moving_average_core_tb
  import tsqma_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AT      = 450;
  localparam int HOLD_CYCLES  = 300;

  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef struct packed {
    err_code_t code;
    temp_t     temp;
  } reading_t;

  // Filter predictor plus the queue of readings still owed by the core
  class mean_scoreboard;
    sample_t  window[WINDOW_LEN];
    int       slot;
    int       window_sum;
    sample_t  low_limit;
    sample_t  high_limit;
    reading_t expected_readings[$];
    int       mismatches;
    int       sample_count;

    function new();
      foreach (window[i]) window[i] = RESET_SAMPLE;
      slot         = 0;
      window_sum   = int'(RESET_SAMPLE) * WINDOW_LEN;
      low_limit    = RESET_LOW_LIMIT;
      high_limit   = RESET_HIGH_LIMIT;
      mismatches   = 0;
      sample_count = 0;
    endfunction

    function void set_limit(logic idx, sample_t value);
      if (idx == CFG_LOW_LIMIT) low_limit = value;
      else high_limit = value;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    // Classify in priority order; only a clean sample enters the ring
    function void note_sample(sample_t s, logic missing);
      reading_t r;
      if (s == SENT_DISCONNECTED) r.code = ERR_OPEN_WIRE;
      else if (s == SENT_CRC) r.code = ERR_CRC;
      else if (s < low_limit || s > high_limit) r.code = ERR_RANGE;
      else if (missing) r.code = ERR_NO_SENSOR;
      else r.code = ERR_OK;

      if (r.code != ERR_OK) begin
        r.temp = ERROR_VALUE;
      end else begin
        window_sum   = window_sum - int'(window[slot]) + int'(s);
        window[slot] = s;
        slot         = (slot + 1) % WINDOW_LEN;
        // int division truncates toward zero
        r.temp = temp_t'((window_sum * SCALE) / (16 * WINDOW_LEN));
      end
      expected_readings.push_back(r);
      sample_count++;
    endfunction

    function void check_reading(err_code_t code, temp_t temp);
      reading_t want;
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: error_code %0d temp_hundredths %0d", code, $signed(temp));
        mismatches++;
        return;
      end
      want = expected_readings.pop_front();
      if (code !== want.code) begin
        $error("error_code: expected %0d, actual %0d", want.code, code);
        mismatches++;
      end
      if (temp !== want.temp) begin
        $error("temp_hundredths: expected %0d, actual %0d", $signed(want.temp), $signed(temp));
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_index;
  logic [SAMPLE_W-1:0] cfg_wdata;

  tsqma_in_if  in_if();
  tsqma_out_if out_if();

  mean_scoreboard sb = new();

  int items_sent    = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 52;

  temp_sample_qualify_moving_average_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 50 MHz clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL temp_sample_qualify_moving_average_core");
    $finish;
  end

  // Result side: check accepted readings, randomize ready, one long hold-off
  initial begin : reading_sink
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready)
        sb.check_reading(out_if.error_code, out_if.temp_hundredths);
      if (!hold_done && sb.sample_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one sample item and wait for it to be taken
  task automatic send_sample(sample_t s, logic missing);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.sample_sixteenths <= s;
    in_if.sensor_missing    <= missing;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_sample(s, missing);
    items_sent++;
    // Idle mix: sender light / receiver heavy, then swapped, then none
    if (items_sent < 200) begin
      send_idle_pct = 10;
      recv_idle_pct = 52;
    end else if (items_sent < 400) begin
      send_idle_pct = 52;
      recv_idle_pct = 10;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Limits are only changed with nothing in flight
  task automatic set_limits(sample_t lo, sample_t hi);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOW_LIMIT;
    cfg_wdata <= lo;
    @(posedge clk);
    sb.set_limit(CFG_LOW_LIMIT, lo);
    cfg_index <= CFG_HIGH_LIMIT;
    cfg_wdata <= hi;
    @(posedge clk);
    sb.set_limit(CFG_HIGH_LIMIT, hi);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly in-limit samples, some sentinels, limit edges and full-range noise
  function automatic sample_t pick_sample(sample_t lo, sample_t hi);
    int r;
    int span;
    r = $urandom_range(99);
    if (r < 5) return SENT_DISCONNECTED;
    if (r < 10) return SENT_CRC;
    if (r < 25 || lo > hi) return sample_t'($urandom_range(4095));
    if (r < 30) return ($urandom_range(1) != 0) ? lo : hi;
    span = int'(hi) - int'(lo);
    return sample_t'(int'(lo) + int'($urandom_range(span)));
  endfunction

  task automatic run_random(sample_t lo, sample_t hi, int count);
    set_limits(lo, hi);
    repeat (count) send_sample(pick_sample(lo, hi), $urandom_range(99) < 12);
  endtask

  initial begin : stimulus
    sample_t lo;
    sample_t hi;
    sample_t tmp;

    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = CFG_LOW_LIMIT;
    cfg_wdata               = '0;
    in_if.valid             = 1'b0;
    in_if.sample_sixteenths = '0;
    in_if.sensor_missing    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset limits, sentinels, limit edges, missing flag priority
    send_sample(400, 1'b0);
    send_sample(SENT_DISCONNECTED, 1'b0);
    send_sample(SENT_DISCONNECTED, 1'b1);
    send_sample(SENT_CRC, 1'b0);
    send_sample(SENT_CRC, 1'b1);
    send_sample(-880, 1'b0);
    send_sample(-881, 1'b0);
    send_sample(2000, 1'b0);
    send_sample(2001, 1'b1);
    send_sample(-2048, 1'b0);
    send_sample(2047, 1'b0);
    send_sample(0, 1'b1);
    send_sample(-879, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(-16, 1'b0);
    send_sample(17, 1'b0);

    // Widest limits: sentinels still reported as their own errors
    set_limits(-2048, 2047);
    send_sample(-2048, 1'b0);
    send_sample(2047, 1'b0);
    send_sample(SENT_CRC, 1'b0);
    send_sample(SENT_DISCONNECTED, 1'b0);
    send_sample(-2047, 1'b0);
    send_sample(-1, 1'b1);

    // Crossed limits: everything but sentinels is out of range
    set_limits(100, -100);
    send_sample(0, 1'b0);
    send_sample(SENT_CRC, 1'b1);
    send_sample(150, 1'b1);

    // Random phases over several limit settings
    run_random(RESET_LOW_LIMIT, RESET_HIGH_LIMIT, 150);
    run_random(-2048, 2047, 100);
    lo = sample_t'($urandom_range(1, 2047));
    run_random(lo, -lo, 40);
    lo = sample_t'($urandom_range(4095));
    run_random(lo, lo, 30);
    repeat (4) begin
      lo = sample_t'($urandom_range(4095));
      hi = sample_t'($urandom_range(4095));
      if (lo > hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      run_random(lo, hi, 50);
    end
    run_random(RESET_LOW_LIMIT, RESET_HIGH_LIMIT, 80);

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS temp_sample_qualify_moving_average_core");
    end else begin
      $display("FAIL temp_sample_qualify_moving_average_core");
    end
    $finish;
  end

endmodule

// File: temp_sample_qualify_moving_average_core.f
+incdir+hdl
hdl/tsqma_pkg.sv
hdl/tsqma_in_if.sv
hdl/tsqma_out_if.sv
hdl/temp_sample_qualify_moving_average_core.sv
dv/temp_sample_qualify_moving_average_core_tb.sv
